// ===== design/array_doubly_linked_list_macros.svh =====
// Assertion helpers shared by the list modules.
// Both expect the module to have i_clk and i_rst_n.
`ifndef ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ADLL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ADLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/adll_pkg.sv =====
`default_nettype none

package adll_pkg;

    localparam int DEFAULT_NODES = 1024;
    localparam int CMD_W         = 3;
    localparam int VAL_W         = 32;
    localparam int ST_W          = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    localparam logic signed [VAL_W-1:0] SENT_VALUE = -32'sd1;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic rd_en;
        logic rd_in;
        logic latch_anchor;
        logic wr_del;
        logic wr_node;
        logic wr_link;
        logic load_out;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic is_ins;
        logic is_del;
        logic bad;
        logic full;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/array_doubly_linked_list.sv =====
// Channel  Handshake          Payload
// -------  -----------------  ------------------------------------------------------
// in       i_valid / o_ready  i_cmd, i_target_node, i_data_value
// out      o_valid / i_ready  o_new_node, o_read_value, o_next_node, o_prev_node,
//                             o_status
//
// One beat in, one beat out; one command in flight at a time.
// Read, delete, rejected and unknown commands finish after the target lookup; a successful push or
// insert runs target lookup, anchor lookup, new-node write and neighbor relink in turn,
// a sequence set by the single read and write port of each link memory.
// The result register lets the next command be taken while a result waits; the
// final step stalls only while that register is still full.
// Reset clears the sentinel links and sets the node count to one (the sentinel); the pool needs no clearing pass.
`default_nettype none

module array_doubly_linked_list
    import adll_pkg::*;
#(
    parameter  int NODES = DEFAULT_NODES,
    localparam int IW    = $clog2(NODES)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire        [CMD_W-1:0]  i_cmd,
    input  wire        [IW-1:0]     i_target_node,
    input  wire signed [VAL_W-1:0]  i_data_value,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic       [IW-1:0]     o_new_node,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic       [IW-1:0]     o_next_node,
    output logic       [IW-1:0]     o_prev_node,
    output logic       [ST_W-1:0]   o_status
);

    t_ctl ctl;
    t_sts sts;

    adll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    adll_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cmd         (i_cmd),
        .i_target_node (i_target_node),
        .i_data_value  (i_data_value),
        .o_new_node    (o_new_node),
        .o_read_value  (o_read_value),
        .o_next_node   (o_next_node),
        .o_prev_node   (o_prev_node),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

// ===== design/adll_ctrl.sv =====
`default_nettype none

`include "array_doubly_linked_list_macros.svh"

module adll_ctrl
    import adll_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    output logic o_valid,
    input  wire  i_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHK   = 2'd1;
    localparam logic [1:0] S_LINK1 = 2'd2;
    localparam logic [1:0] S_LINK2 = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       out_free;
    t_ctl       ctl;
    logic       ready;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        ctl     = '0;
        ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                ready = 1'b1;
                if (i_valid) begin
                    ctl.latch_in = 1'b1;
                    ctl.rd_en    = 1'b1;
                    ctl.rd_in    = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.is_ins && !i_sts.bad && !i_sts.full) begin
                    // fetch the anchor's next link
                    ctl.rd_en        = 1'b1;
                    ctl.latch_anchor = 1'b1;
                    n_state          = S_LINK1;
                end else if (out_free) begin
                    ctl.wr_del   = i_sts.is_del && !i_sts.bad;
                    ctl.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LINK1: begin
                ctl.wr_node = 1'b1;
                n_state     = S_LINK2;
            end
            S_LINK2: begin
                if (out_free) begin
                    ctl.wr_link  = 1'b1;
                    ctl.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready = ready;
    assign o_valid = r_out_valid;
    assign o_ctl   = ctl;

    `ADLL_ASSERT_NOW(a_no_overwrite, ctl.load_out, out_free, "result beat overwritten")
    `ADLL_ASSERT_NEXT(a_link_seq, r_state == S_LINK1, r_state == S_LINK2, "link steps out of order")
    `ADLL_ASSERT_NEXT(a_load_shows, ctl.load_out, r_out_valid, "loaded result not presented")

endmodule

`default_nettype wire

// ===== design/adll_dp.sv =====
`default_nettype none

`include "array_doubly_linked_list_macros.svh"

module adll_dp
    import adll_pkg::*;
#(
    parameter  int NODES = DEFAULT_NODES,
    localparam int IW    = $clog2(NODES),
    localparam int CW    = $clog2(NODES + 1)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_ctl                    i_ctl,
    output t_sts                    o_sts,
    input  wire        [CMD_W-1:0]  i_cmd,
    input  wire        [IW-1:0]     i_target_node,
    input  wire signed [VAL_W-1:0]  i_data_value,
    output logic       [IW-1:0]     o_new_node,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic       [IW-1:0]     o_next_node,
    output logic       [IW-1:0]     o_prev_node,
    output logic       [ST_W-1:0]   o_status
);

    // entry 0 of the link stores lives in r_sent_*; the memories hold nodes 1 and up
    logic        [IW-1:0]    next_mem [NODES];
    logic        [IW-1:0]    prev_mem [NODES];
    logic signed [VAL_W-1:0] val_mem  [NODES];
    logic                    live_mem [NODES];

    logic        [CMD_W-1:0] r_cmd;
    logic        [IW-1:0]    r_t;
    logic signed [VAL_W-1:0] r_val;
    logic        [IW-1:0]    r_a;
    logic        [IW-1:0]    r_b;
    logic        [IW-1:0]    r_rd_next;
    logic        [IW-1:0]    r_rd_prev;
    logic signed [VAL_W-1:0] r_rd_val;
    logic                    r_rd_live;
    logic        [CW-1:0]    r_alloc;
    logic        [IW-1:0]    r_sent_next;
    logic        [IW-1:0]    r_sent_prev;

    logic        [IW-1:0]    r_new_node;
    logic signed [VAL_W-1:0] r_read_value;
    logic        [IW-1:0]    r_next_node;
    logic        [IW-1:0]    r_prev_node;
    logic        [ST_W-1:0]  r_status;

    logic        [IW-1:0]    new_idx;
    logic        [IW-1:0]    t_next;
    logic        [IW-1:0]    t_prev;
    logic        [IW-1:0]    anchor;
    logic        [IW-1:0]    b_link;
    logic        [IW-1:0]    rd_addr;
    logic                    tgt_ok;
    logic                    in_range;
    logic                    is_read;
    t_sts                    sts;

    logic                    nx_sel;
    logic        [IW-1:0]    nx_wa;
    logic        [IW-1:0]    nx_wd;
    logic                    pv_sel;
    logic        [IW-1:0]    pv_wa;
    logic        [IW-1:0]    pv_wd;
    logic                    lv_we;
    logic        [IW-1:0]    lv_wa;
    logic                    lv_wd;

    logic        [IW-1:0]    res_new;
    logic signed [VAL_W-1:0] res_val;
    logic        [IW-1:0]    res_next;
    logic        [IW-1:0]    res_prev;
    logic        [ST_W-1:0]  res_st;

    assign new_idx  = r_alloc[IW-1:0];
    assign t_next   = (r_t == '0) ? r_sent_next : r_rd_next;
    assign t_prev   = (r_t == '0) ? r_sent_prev : r_rd_prev;
    assign in_range = {{(CW-IW){1'b0}}, r_t} < r_alloc;
    assign tgt_ok   = (r_t != '0) && in_range && r_rd_live;
    assign is_read  = (r_cmd == CMD_READ);

    always_comb begin
        sts        = '0;
        sts.is_ins = r_cmd inside {CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INS_BEFORE, CMD_INS_AFTER};
        sts.is_del = (r_cmd == CMD_DELETE);
        sts.full   = (r_alloc >= CW'(NODES));
        case (r_cmd)
            CMD_DELETE, CMD_INS_BEFORE, CMD_INS_AFTER: sts.bad = !tgt_ok;
            CMD_READ:                                  sts.bad = !in_range;
            default:                                   sts.bad = 1'b0;
        endcase
    end

    always_comb begin
        case (r_cmd)
            CMD_PUSH_FRONT: anchor = '0;
            CMD_PUSH_BACK:  anchor = r_sent_prev;
            CMD_INS_BEFORE: anchor = t_prev;
            default:        anchor = r_t;
        endcase
    end

    assign rd_addr = i_ctl.rd_in ? i_target_node : anchor;
    assign b_link  = (r_a == '0) ? r_sent_next : r_rd_next;

    // write port selection for the link and live stores
    always_comb begin
        nx_sel = 1'b0;
        nx_wa  = '0;
        nx_wd  = '0;
        pv_sel = 1'b0;
        pv_wa  = '0;
        pv_wd  = '0;
        lv_we  = 1'b0;
        lv_wa  = '0;
        lv_wd  = 1'b0;
        if (i_ctl.wr_del) begin
            nx_sel = 1'b1;
            nx_wa  = t_prev;
            nx_wd  = t_next;
            pv_sel = 1'b1;
            pv_wa  = t_next;
            pv_wd  = t_prev;
            lv_we  = 1'b1;
            lv_wa  = r_t;
            lv_wd  = 1'b0;
        end else if (i_ctl.wr_node) begin
            nx_sel = 1'b1;
            nx_wa  = new_idx;
            nx_wd  = b_link;
            pv_sel = 1'b1;
            pv_wa  = new_idx;
            pv_wd  = r_a;
            lv_we  = 1'b1;
            lv_wa  = new_idx;
            lv_wd  = 1'b1;
        end else if (i_ctl.wr_link) begin
            nx_sel = 1'b1;
            nx_wa  = r_a;
            nx_wd  = new_idx;
            pv_sel = 1'b1;
            pv_wa  = r_b;
            pv_wd  = new_idx;
        end
    end

    always_comb begin
        res_new  = '0;
        res_val  = '0;
        res_next = '0;
        res_prev = '0;
        res_st   = ST_OK;
        if (i_ctl.wr_link) begin
            res_new = new_idx;
        end else if (sts.is_ins) begin
            res_st = sts.bad ? ST_BAD : ST_FULL;
        end else if (sts.is_del) begin
            res_st = sts.bad ? ST_BAD : ST_OK;
        end else if (is_read) begin
            if (sts.bad) begin
                res_st = ST_BAD;
            end else begin
                res_val  = (r_t == '0) ? SENT_VALUE : r_rd_val;
                res_next = t_next;
                res_prev = t_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) begin
            r_cmd <= i_cmd;
            r_t   <= i_target_node;
            r_val <= i_data_value;
        end
        if (i_ctl.latch_anchor) begin
            r_a <= anchor;
        end
        if (i_ctl.wr_node) begin
            r_b <= b_link;
        end
        if (i_ctl.rd_en) begin
            r_rd_next <= next_mem[rd_addr];
            r_rd_prev <= prev_mem[rd_addr];
            r_rd_val  <= val_mem[rd_addr];
            r_rd_live <= live_mem[rd_addr];
        end
        if (nx_sel && nx_wa != '0) begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_sel && pv_wa != '0) begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (lv_we) begin
            live_mem[lv_wa] <= lv_wd;
        end
        if (i_ctl.wr_node) begin
            val_mem[new_idx] <= r_val;
        end
        if (i_ctl.load_out) begin
            r_new_node   <= res_new;
            r_read_value <= res_val;
            r_next_node  <= res_next;
            r_prev_node  <= res_prev;
            r_status     <= res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc     <= CW'(1);
            r_sent_next <= '0;
            r_sent_prev <= '0;
        end else begin
            if (nx_sel && nx_wa == '0) begin
                r_sent_next <= nx_wd;
            end
            if (pv_sel && pv_wa == '0) begin
                r_sent_prev <= pv_wd;
            end
            if (i_ctl.wr_link) begin
                r_alloc <= r_alloc + CW'(1);
            end
        end
    end

    assign o_sts        = sts;
    assign o_new_node   = r_new_node;
    assign o_read_value = r_read_value;
    assign o_next_node  = r_next_node;
    assign o_prev_node  = r_prev_node;
    assign o_status     = r_status;

    `ADLL_ASSERT_NOW(a_alloc_bound, 1'b1, r_alloc <= CW'(NODES), "node count past pool size")
    `ADLL_ASSERT_NOW(a_node_room, i_ctl.wr_node, r_alloc < CW'(NODES), "node written into full pool")
    `ADLL_ASSERT_NEXT(a_alloc_step, i_ctl.wr_link, r_alloc == $past(r_alloc) + CW'(1), "count not advanced")

endmodule

`default_nettype wire
